>>> hw/rtl/section_to_ts_packetizer_macros.svh
// Assertion macros shared by the packetizer checker.
`ifndef SECTION_TO_TS_PACKETIZER_MACROS_SVH
`define SECTION_TO_TS_PACKETIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STPK_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packetizer check failed");

// Next-cycle implication, disabled during reset.
`define STPK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packetizer check failed");

`endif

>>> hw/rtl/stpk_pkg.sv
// Types and constants shared by the section to transport packetizer.
package stpk_pkg;

  localparam logic [7:0] TS_BYTES    = 8'd188;
  localparam logic [7:0] SYNC_BYTE   = 8'h47;
  localparam logic [7:0] STUFF_BYTE  = 8'hFF;
  localparam logic [3:0] AFC_PAYLOAD = 4'b0001;
  localparam logic [4:0] PCOUNT_MAX  = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_BYTE,
    ST_STUFF
  } stpk_state_t;

  typedef struct packed {
    logic accept;
    logic hdr;
    logic byte_put;
    logic stuff;
  } stpk_cmd_t;

  typedef struct packed {
    logic open_needed;
    logic slot_free;
    logic byte_emits;
    logic byte_ends;
    logic stuff_ends;
    logic last;
  } stpk_status_t;

endpackage

>>> hw/rtl/stpk_ifs.sv
// Stream interfaces for the section byte input and the packet word output.
interface stpk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface stpk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        packet_first_word;
  logic        section_done;
  logic [4:0]  packet_count;
  logic        run_last;

  modport source (
    output valid, output out_word, output packet_first_word, output section_done,
    output packet_count, output run_last, input ready
  );
  modport sink (
    input valid, input out_word, input packet_first_word, input section_done,
    input packet_count, input run_last, output ready
  );
endinterface

>>> hw/rtl/section_to_ts_packetizer.sv
// Top level of the section to transport stream packetizer.
// Section bytes enter on byte_ch, one per item, with last_byte on the final
// byte. Packet words leave on word_ch as 32-bit big-endian words, each
// tagged with header, section end, packet count and end-of-run flags.
// The PID is written through cfg_we and cfg_data and is used from the next
// packet header onwards.
// Each byte is accepted and then placed; a byte that opens a packet also
// passes the header step for the header word. The last byte of a section
// then emits one stuffing word per cycle while the receiver takes them,
// until the packet is full, up to 46 words. The controller runs one step
// per cycle unless stalled and accepts no byte until the last is placed.
// A finished word sits in the output register; the next byte can be
// accepted while it waits. When the receiver stalls, the controller holds
// at the step that would produce the next word.
// Reset is synchronous and clears the PID, closes any section and empties
// the output register.
module section_to_ts_packetizer
  import stpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  stpk_in_if.sink     byte_ch,
  stpk_out_if.source  word_ch,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data
);

  stpk_cmd_t    cmd;
  stpk_status_t status;

  stpk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_ch.valid),
    .in_ready (byte_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  stpk_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .data_byte (byte_ch.data_byte),
    .last_byte (byte_ch.last_byte),
    .cmd       (cmd),
    .status    (status),
    .word_ch   (word_ch)
  );

endmodule

>>> hw/rtl/stpk_ctrl.sv
// Controller state machine that sequences header, byte and stuffing steps.
module stpk_ctrl
  import stpk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  stpk_status_t status,
  output stpk_cmd_t    cmd
);

  stpk_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.open_needed ? ST_HDR : ST_BYTE;
        end
      end
      ST_HDR: begin
        if (status.slot_free) begin
          cmd.hdr    = 1'b1;
          state_next = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (!status.byte_emits || status.slot_free) begin
          cmd.byte_put = 1'b1;
          state_next   = (status.last && !status.byte_ends) ? ST_STUFF : ST_IDLE;
        end
      end
      ST_STUFF: begin
        if (status.slot_free) begin
          cmd.stuff = 1'b1;
          if (status.stuff_ends) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/stpk_dpath.sv
// Datapath: packet position, counters, word assembly and the output register.
module stpk_dpath
  import stpk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_data,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  stpk_cmd_t         cmd,
  output stpk_status_t      status,
  stpk_out_if.source        word_ch
);

  logic [12:0] pid;
  logic [7:0]  pos;
  logic [4:0]  idx;
  logic [3:0]  cc;
  logic [23:0] asm_word;
  logic [1:0]  fill;
  logic        open;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        out_valid;

  logic [7:0]  pos_inc;
  logic [7:0]  pos_stuff;
  logic        first;
  logic        emit;
  logic [31:0] word_next;
  logic        pfw_next;
  logic        done_next;
  logic        rlast_next;
  logic [31:0] stuff_word;

  assign pos_inc   = pos + 8'd1;
  assign pos_stuff = pos + (8'd4 - {6'd0, fill});
  assign first     = (idx == 5'd0);
  assign emit      = cmd.hdr || (cmd.byte_put && (fill == 2'd3)) || cmd.stuff;

  assign status.open_needed = !open || (pos >= TS_BYTES);
  assign status.slot_free   = !out_valid || word_ch.ready;
  assign status.byte_emits  = (fill == 2'd3);
  assign status.byte_ends   = (pos_inc == TS_BYTES);
  assign status.stuff_ends  = (pos_stuff == TS_BYTES);
  assign status.last        = last_r;

  always_comb begin
    case (fill)
      2'd0:    stuff_word = {STUFF_BYTE, STUFF_BYTE, STUFF_BYTE, STUFF_BYTE};
      2'd1:    stuff_word = {asm_word[7:0], STUFF_BYTE, STUFF_BYTE, STUFF_BYTE};
      2'd2:    stuff_word = {asm_word[15:0], STUFF_BYTE, STUFF_BYTE};
      default: stuff_word = {asm_word, STUFF_BYTE};
    endcase
  end

  always_comb begin
    word_next  = stuff_word;
    pfw_next   = 1'b0;
    done_next  = 1'b0;
    rlast_next = 1'b0;
    if (cmd.hdr) begin
      word_next  = {SYNC_BYTE, 1'b0, first, 1'b0, pid[12:8], pid[7:0], AFC_PAYLOAD, cc};
      pfw_next   = 1'b1;
      rlast_next = !last_r;
    end else if (cmd.byte_put) begin
      word_next  = {asm_word, byte_r};
      done_next  = last_r && (pos_inc == TS_BYTES);
      rlast_next = !last_r || (pos_inc == TS_BYTES);
    end else begin
      done_next  = (pos_stuff == TS_BYTES);
      rlast_next = (pos_stuff == TS_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pid       <= 13'd0;
      pos       <= TS_BYTES;
      idx       <= 5'd0;
      cc        <= 4'd0;
      asm_word  <= 24'd0;
      fill      <= 2'd0;
      open      <= 1'b0;
      byte_r    <= 8'd0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pid <= cfg_data;
      end
      if (cmd.accept) begin
        byte_r <= data_byte;
        last_r <= last_byte;
        if (!open) begin
          idx      <= 5'd0;
          cc       <= 4'd0;
          pos      <= TS_BYTES;
          asm_word <= 24'd0;
          fill     <= 2'd0;
          open     <= 1'b1;
        end
      end
      if (cmd.hdr) begin
        pos      <= first ? 8'd5 : 8'd4;
        fill     <= first ? 2'd1 : 2'd0;
        asm_word <= 24'd0;
        cc       <= cc + 4'd1;
        if (idx != PCOUNT_MAX) begin
          idx <= idx + 5'd1;
        end
      end
      if (cmd.byte_put) begin
        pos <= pos_inc;
        if (fill == 2'd3) begin
          asm_word <= 24'd0;
          fill     <= 2'd0;
        end else begin
          asm_word <= {asm_word[15:0], byte_r};
          fill     <= fill + 2'd1;
        end
        if (last_r && (pos_inc == TS_BYTES)) begin
          open <= 1'b0;
        end
      end
      if (cmd.stuff) begin
        pos      <= pos_stuff;
        asm_word <= 24'd0;
        fill     <= 2'd0;
        if (pos_stuff == TS_BYTES) begin
          open <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (word_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_ch.out_word          <= word_next;
      word_ch.packet_first_word <= pfw_next;
      word_ch.section_done      <= done_next;
      word_ch.packet_count      <= done_next ? idx : 5'd0;
      word_ch.run_last          <= rlast_next;
    end
  end

  assign word_ch.valid = out_valid;

endmodule

>>> hw/rtl/stpk_checker.sv
// Port-level checker for the packetizer and its bind to the top level.
`include "section_to_ts_packetizer_macros.svh"

module stpk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        section_done,
  input logic [4:0]  packet_count,
  input logic        run_last
);

  `STPK_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_word))
  `STPK_ASSERT_NOW(a_done_ends_run, clk, rst, out_valid && section_done, run_last)
  `STPK_ASSERT_NOW(a_count_only_done, clk, rst, out_valid && !section_done,
                   packet_count == 5'd0)
  `STPK_ASSERT_NOW(a_done_has_count, clk, rst, out_valid && section_done,
                   packet_count != 5'd0)
  `STPK_ASSERT_NEXT(a_one_item_at_once, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind section_to_ts_packetizer stpk_checker u_stpk_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (byte_ch.valid),
  .in_ready     (byte_ch.ready),
  .out_valid    (word_ch.valid),
  .out_ready    (word_ch.ready),
  .out_word     (word_ch.out_word),
  .section_done (word_ch.section_done),
  .packet_count (word_ch.packet_count),
  .run_last     (word_ch.run_last)
);
